// ----- hw/rtl/drive_saturation_tone_lowpass_top_assert.svh -----
// ----------------------------------------------------------------------------
// drive saturation tone lowpass assertion macros
// concurrent check macros for the drive/tone block, empty with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef DRIVE_SATURATION_TONE_LOWPASS_TOP_ASSERT_SVH
`define DRIVE_SATURATION_TONE_LOWPASS_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define DSTL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dstl: same-cycle check failed");
// next-cycle implication
`define DSTL_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dstl: next-cycle check failed");
`else
`define DSTL_ASSERT_NOW(label, ante, cons)
`define DSTL_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- hw/rtl/dstl_pkg.sv -----
// ----------------------------------------------------------------------------
// dstl_pkg
// shared constants for the drive saturation and tone lowpass block
// ----------------------------------------------------------------------------
`default_nettype none

package dstl_pkg;

  // parameter defaults
  localparam int DEF_TANH_TABLE_ENTRIES = 256;
  localparam int DEF_SAMPLE_BITS        = 24;

  // register field widths
  localparam int GAIN_W     = 17;
  localparam int COMP_W     = 16;
  localparam int COEFF_W    = 16;
  localparam int LP_STATE_W = 32;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 17;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DRIVE_ENABLE,
    REG_DRIVE_GAIN,
    REG_DRIVE_COMP,
    REG_TONE_ENABLE,
    REG_TONE_COEFF,
    REG_STEREO_ENABLE
  } cfg_reg_t;

  // register reset values
  localparam logic              RST_DRIVE_ENABLE  = 1'b0;
  localparam logic [GAIN_W-1:0]  RST_DRIVE_GAIN    = 17'd16384;
  localparam logic [COMP_W-1:0]  RST_DRIVE_COMP    = 16'd32768;
  localparam logic              RST_TONE_ENABLE   = 1'b0;
  localparam logic [COEFF_W-1:0] RST_TONE_COEFF    = 16'd51708;
  localparam logic              RST_STEREO_ENABLE = 1'b1;

endpackage

`default_nettype wire

// ----- hw/rtl/drive_saturation_tone_lowpass_top.sv -----
// ----------------------------------------------------------------------------
// drive_saturation_tone_lowpass_top
// tanh soft clip with gain/compensation and a one-pole tpt lowpass per channel
// ----------------------------------------------------------------------------
// One stereo frame goes in per input word and one frame comes out per output
// word. A small sequencer walks each channel through its steps on a single
// shared signed multiplier and a registered tanh rom, so in_ready is high only
// while the sequencer is idle. A frame runs from idle through each processed
// channel and then a hand-off step. Per channel the clip steps run when drive
// is on (skipping the table read when the scaled input is past the table
// end), then the lowpass steps when tone is on, then the store. In mono only
// the left channel is processed. The finished frame sits in
// an output register, so the next word is accepted while it waits.
// The tanh table (TANH_TABLE_ENTRIES + 1 points) is built at elaboration and
// needs no fill after reset. Configuration writes are taken in any cycle
// (cfg_ready is always high) and must only happen while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module drive_saturation_tone_lowpass_top
  import dstl_pkg::*;
#(
  parameter int TANH_TABLE_ENTRIES = DEF_TANH_TABLE_ENTRIES,
  parameter int SAMPLE_BITS        = DEF_SAMPLE_BITS
) (
  input  wire                           clk,
  input  wire                           rst,
  // input frame word
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire signed [SAMPLE_BITS-1:0]  left_in,
  input  wire signed [SAMPLE_BITS-1:0]  right_in,
  // output frame word
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic signed [SAMPLE_BITS-1:0] left_out,
  output logic signed [SAMPLE_BITS-1:0] right_out,
  // configuration write word
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire [CFG_INDEX_W-1:0]         cfg_index,
  input  wire [CFG_DATA_W-1:0]          cfg_data
);

`include "drive_saturation_tone_lowpass_top_assert.svh"

  // --------------------------------------------------------------------------
  // widths
  // --------------------------------------------------------------------------
  localparam int FRAC      = SAMPLE_BITS - 1;
  localparam int TAB_DEPTH = TANH_TABLE_ENTRIES + 1;
  localparam int IDX_W     = $clog2(TANH_TABLE_ENTRIES);
  localparam int TAB_AW    = $clog2(TAB_DEPTH);
  localparam int T_W       = FRAC + 1;            // interpolated tanh, up to one
  localparam int DIF_W     = 33;                  // multiplier operand a, signed
  localparam int MB_W      = SAMPLE_BITS + 2;     // multiplier operand b, signed
  localparam int PROD_W    = DIF_W + MB_W;
  localparam int Y_W       = 34;                  // lowpass output before clamp
  localparam int NS_W      = 35;                  // new lowpass state before clamp
  localparam int SAT_W     = 36;                  // input width of the sample clamp
  localparam int GAIN_SH   = 14;                  // unsigned q3.14 gain
  localparam int COMP_SH   = 15;                  // q1.15 compensation

  localparam logic signed [SAT_W-1:0] SMP_MAX = (36'sd1 <<< FRAC) - 36'sd1;
  localparam logic signed [SAT_W-1:0] SMP_MIN = -(36'sd1 <<< FRAC);
  localparam logic signed [NS_W-1:0]  LP_MAX  = (35'sd1 <<< (LP_STATE_W - 1)) - 35'sd1;
  localparam logic signed [NS_W-1:0]  LP_MIN  = -(35'sd1 <<< (LP_STATE_W - 1));

  // --------------------------------------------------------------------------
  // tanh table, worked out at elaboration
  // exp(-8k/n) from a 10-term series squared four times, then (1-e)/(1+e)
  // --------------------------------------------------------------------------
  typedef logic [FRAC-1:0] tab_t [TAB_DEPTH];

  // shift and subtract quotient, only used for the table math
  function automatic logic [63:0] udiv(input logic [63:0] dvd, input logic [63:0] dvs);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], dvd[b]};
      if (rem >= {1'b0, dvs}) begin
        rem    = rem - {1'b0, dvs};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] tanh_entry(input int unsigned k);
    longint      q30;
    longint      r;
    longint      e;
    longint      term;
    logic [63:0] tq;
    logic [63:0] num;
    logic [63:0] den;
    q30  = longint'(1) << 30;
    tq   = udiv(64'(k) << 33, 64'(TANH_TABLE_ENTRIES));
    r    = longint'(tq >> 4);
    e    = q30;
    term = q30;
    for (int n = 1; n <= 10; n++) begin
      term = longint'(udiv(64'((term * r) >>> 30), 64'(n)));
      if ((n & 1) == 1) e = e - term;
      else              e = e + term;
    end
    for (int n = 0; n < 4; n++) begin
      e = (e * e + (longint'(1) << 29)) >>> 30;
    end
    if (e > q30) e = q30;
    if (e < 0)   e = 0;
    num = 64'((q30 - e) << FRAC);
    den = 64'(q30 + e);
    return udiv(num, den);
  endfunction

  function automatic tab_t build_tab();
    tab_t        tab;
    logic [63:0] t;
    logic [63:0] prev;
    prev = '0;
    for (int k = 0; k < TAB_DEPTH; k++) begin
      t = tanh_entry(unsigned'(k));
      if (k > 0 && t < prev) t = prev;   // keep the table monotone
      tab[k] = t[FRAC-1:0];
      prev   = t;
    end
    return tab;
  endfunction

  localparam tab_t TANH_TAB = build_tab();

  // clamp to the sample range
  function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(input logic signed [SAT_W-1:0] v);
    logic signed [SAMPLE_BITS-1:0] r;
    if (v > SMP_MAX)      r = SMP_MAX[SAMPLE_BITS-1:0];
    else if (v < SMP_MIN) r = SMP_MIN[SAMPLE_BITS-1:0];
    else                  r = v[SAMPLE_BITS-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic               drive_enable;
  logic [GAIN_W-1:0]  drive_gain;
  logic [COMP_W-1:0]  drive_comp;
  logic               tone_enable;
  logic [COEFF_W-1:0] tone_coeff;
  logic               stereo_enable;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_enable  <= RST_DRIVE_ENABLE;
      drive_gain    <= RST_DRIVE_GAIN;
      drive_comp    <= RST_DRIVE_COMP;
      tone_enable   <= RST_TONE_ENABLE;
      tone_coeff    <= RST_TONE_COEFF;
      stereo_enable <= RST_STEREO_ENABLE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DRIVE_ENABLE:  drive_enable  <= cfg_data[0];
        REG_DRIVE_GAIN:    drive_gain    <= cfg_data[GAIN_W-1:0];
        REG_DRIVE_COMP:    drive_comp    <= cfg_data[COMP_W-1:0];
        REG_TONE_ENABLE:   tone_enable   <= cfg_data[0];
        REG_TONE_COEFF:    tone_coeff    <= cfg_data[COEFF_W-1:0];
        REG_STEREO_ENABLE: stereo_enable <= cfg_data[0];
        default: ;   // indexes past the list are dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // sequencer states
  // --------------------------------------------------------------------------
  typedef enum logic [4:0] {
    S_IDLE,    // wait for a frame
    S_CH,      // pick the channel sample, take its magnitude
    S_GAIN,    // mul: magnitude * drive_gain
    S_POS,     // mul: scaled magnitude * table size, or saturate past the end
    S_IDX,     // split table position, read the lower point
    S_RD1,     // read the upper point
    S_DTAB,    // slope between the two points
    S_INTERP,  // mul: slope * fraction
    S_TSUM,    // interpolated tanh
    S_COMP,    // mul: tanh * drive_comp
    S_SIGN,    // restore sign and clamp
    S_DIFF,    // lowpass input minus state
    S_LP,      // mul: difference * tone_coeff
    S_LPY,     // v and y
    S_LPS,     // new state and clamped output
    S_STORE,   // channel result, move to the next channel
    S_DONE     // hand the frame to the output register
  } state_t;

  state_t state;

  // datapath registers
  logic                           ch;        // 0 left, 1 right
  logic signed [SAMPLE_BITS-1:0]  in_l;
  logic signed [SAMPLE_BITS-1:0]  in_r;
  logic signed [SAMPLE_BITS-1:0]  x_d;       // running channel value
  logic [SAMPLE_BITS-1:0]         mag;
  logic                           neg;
  logic signed [PROD_W-1:0]       prod;
  logic [IDX_W-1:0]               idx;
  logic [FRAC+1:0]                fr;
  logic [FRAC-1:0]                t0;
  logic [FRAC-1:0]                rom_q;
  logic [T_W-1:0]                 t;
  logic signed [DIF_W-1:0]        dif;
  logic signed [DIF_W-1:0]        v;
  logic signed [Y_W-1:0]          y;
  logic signed [SAMPLE_BITS-1:0]  res_l;
  logic signed [SAMPLE_BITS-1:0]  res_r;
  logic signed [LP_STATE_W-1:0]   lp_l;
  logic signed [LP_STATE_W-1:0]   lp_r;

  // --------------------------------------------------------------------------
  // combinational helpers
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_BITS-1:0]  cur;
  logic signed [LP_STATE_W-1:0]   s_ch;
  logic                           g_over;
  logic [FRAC+1:0]                g_low;
  logic [IDX_W-1:0]               p_idx;
  logic [FRAC+1:0]                p_fr;
  logic [FRAC+1:0]                c_mag;
  logic signed [SAMPLE_BITS+1:0]  c_sgn;
  logic signed [DIF_W-1:0]        v_q;
  logic signed [NS_W-1:0]         ns;
  logic signed [LP_STATE_W-1:0]   ns_sat;
  logic [TAB_AW-1:0]              rom_addr;
  logic                           out_load;

  assign cur    = ch ? in_r : in_l;
  assign s_ch   = ch ? lp_r : lp_l;

  // scaled magnitude g = prod >> 14; past the table end once g reaches 4.0
  assign g_over = |prod[PROD_W-1:FRAC+2+GAIN_SH];
  assign g_low  = prod[FRAC+1+GAIN_SH:GAIN_SH];

  // table position g * n: integer part indexes, low bits interpolate
  assign p_idx  = prod[FRAC+2 +: IDX_W];
  assign p_fr   = prod[FRAC+1:0];

  // compensated magnitude and its signed form
  assign c_mag  = prod[FRAC+1+COMP_SH:COMP_SH];
  assign c_sgn  = neg ? -$signed({1'b0, c_mag}) : $signed({1'b0, c_mag});

  // v = floor((x - s) * g / 2^16)
  assign v_q    = $signed(prod[COEFF_W +: DIF_W]);

  assign ns     = NS_W'(y) + NS_W'(v);
  always_comb begin
    if (ns > LP_MAX)      ns_sat = LP_MAX[LP_STATE_W-1:0];
    else if (ns < LP_MIN) ns_sat = LP_MIN[LP_STATE_W-1:0];
    else                  ns_sat = ns[LP_STATE_W-1:0];
  end

  // --------------------------------------------------------------------------
  // shared multiplier: operand select, product registered
  // --------------------------------------------------------------------------
  logic signed [DIF_W-1:0] mul_a;
  logic signed [MB_W-1:0]  mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_GAIN: begin
        mul_a = $signed({{(DIF_W-SAMPLE_BITS){1'b0}}, mag});
        mul_b = $signed({{(MB_W-GAIN_W){1'b0}}, drive_gain});
      end
      S_POS: begin
        mul_a = DIF_W'(TANH_TABLE_ENTRIES);
        mul_b = $signed({1'b0, g_low});
      end
      S_INTERP: begin
        mul_a = dif;
        mul_b = $signed({1'b0, fr});
      end
      S_COMP: begin
        mul_a = $signed({{(DIF_W-T_W){1'b0}}, t});
        mul_b = $signed({{(MB_W-COMP_W){1'b0}}, drive_comp});
      end
      S_LP: begin
        mul_a = dif;
        mul_b = $signed({{(MB_W-COEFF_W){1'b0}}, tone_coeff});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // --------------------------------------------------------------------------
  // tanh rom, one registered read a cycle
  // --------------------------------------------------------------------------
  assign rom_addr = (state == S_IDX) ? TAB_AW'(p_idx) : (TAB_AW'(idx) + TAB_AW'(1));

  always_ff @(posedge clk) begin
    rom_q <= TANH_TAB[rom_addr];
  end

  // --------------------------------------------------------------------------
  // handshakes
  // --------------------------------------------------------------------------
  assign in_ready = (state == S_IDLE);
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  // --------------------------------------------------------------------------
  // sequencer and datapath
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ch        <= 1'b0;
      out_valid <= 1'b0;
      lp_l      <= '0;
      lp_r      <= '0;
    end else begin
      // output register: loaded from the sequencer, emptied by the sink
      if (out_load)                    out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            in_l  <= left_in;
            in_r  <= right_in;
            res_r <= '0;          // stays zero in mono
            ch    <= 1'b0;
            state <= S_CH;
          end
        end
        S_CH: begin
          x_d <= cur;
          neg <= cur[SAMPLE_BITS-1];
          mag <= cur[SAMPLE_BITS-1] ? SAMPLE_BITS'(-cur) : SAMPLE_BITS'(cur);
          if (drive_enable)     state <= S_GAIN;
          else if (tone_enable) state <= S_DIFF;
          else                  state <= S_STORE;
        end
        S_GAIN: state <= S_POS;
        S_POS: begin
          if (g_over) begin
            t     <= T_W'(1) << FRAC;   // past the table end: exactly one
            state <= S_COMP;
          end else begin
            state <= S_IDX;
          end
        end
        S_IDX: begin
          idx   <= p_idx;
          fr    <= p_fr;
          state <= S_RD1;
        end
        S_RD1: begin
          t0    <= rom_q;
          state <= S_DTAB;
        end
        S_DTAB: begin
          dif   <= $signed(DIF_W'(rom_q) - DIF_W'(t0));
          state <= S_INTERP;
        end
        S_INTERP: state <= S_TSUM;
        S_TSUM: begin
          t     <= T_W'(t0) + T_W'(prod[FRAC+2 +: FRAC]);
          state <= S_COMP;
        end
        S_COMP: state <= S_SIGN;
        S_SIGN: begin
          x_d   <= sat_smp(SAT_W'(c_sgn));
          state <= tone_enable ? S_DIFF : S_STORE;
        end
        S_DIFF: begin
          dif   <= DIF_W'(x_d) - DIF_W'(s_ch);
          state <= S_LP;
        end
        S_LP: state <= S_LPY;
        S_LPY: begin
          v     <= v_q;
          y     <= Y_W'(v_q) + Y_W'(s_ch);
          state <= S_LPS;
        end
        S_LPS: begin
          if (ch) lp_r <= ns_sat;
          else    lp_l <= ns_sat;
          x_d   <= sat_smp(SAT_W'(y));
          state <= S_STORE;
        end
        S_STORE: begin
          if (ch) res_r <= x_d;
          else    res_l <= x_d;
          if (!ch && stereo_enable) begin
            ch    <= 1'b1;
            state <= S_CH;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            left_out  <= res_l;
            right_out <= res_r;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  `DSTL_ASSERT_NXT(a_accept_starts, in_valid && in_ready, state == S_CH && !ch)
  `DSTL_ASSERT_NXT(a_done_presents, out_load, out_valid && state == S_IDLE)
  `DSTL_ASSERT_NOW(a_tanh_le_one, state == S_COMP, t <= (T_W'(1) << FRAC))
  `DSTL_ASSERT_NOW(a_tab_monotone, state == S_DTAB, rom_q >= t0)

endmodule

`default_nettype wire
